### hw/rtl/dprle_pkg.sv
// dprle_pkg: shared types and constants for the dash pattern run-length encoder
// holds the transfer payload structs and the sequencer state type
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package dprle_pkg;

  localparam int TAG_W       = 8;
  localparam int PAT_W       = 16;
  localparam int IDX_W       = 4;
  localparam int RUN_W       = 5;
  localparam int MAX_RESULTS = 16;

  typedef struct packed {
    logic signed [TAG_W-1:0] slot_tag;
    logic [PAT_W-1:0]        pattern;
  } dprle_in_t;

  typedef struct packed {
    logic signed [TAG_W-1:0] slot_tag_out;
    logic [IDX_W-1:0]        run_index;
    logic [RUN_W-1:0]        run_length;
    logic [RUN_W-1:0]        start_offset;
    logic [RUN_W-1:0]        run_count;
    logic                    last_run;
  } dprle_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT,
    ST_TAIL
  } dprle_state_t;

endpackage

`default_nettype wire

### hw/rtl/dash_pattern_run_length_encoder_core.sv
// dash_pattern_run_length_encoder_core: turns a line-style pattern into a dash list
// bit-serial scan pass then bit-serial emit pass over one pattern shift register
// depends on dprle_pkg
//
//   channel | ports                        | direction | payload
//   --------+------------------------------+-----------+-------------
//   in      | in_valid, in_stall, in_data  | in        | dprle_in_t
//   out     | out_valid, out_stall, out_data | out     | dprle_out_t
//
// an item passes through ST_IDLE, which takes the transfer, ST_SCAN, which counts
// the offset and runs, ST_EMIT, which shifts the runs out, and ST_TAIL, which sends
// the appended offset element, if any; an out side stall holds ST_EMIT and ST_TAIL
// the pattern shift register, walked once per pass, shifts one bit per cycle unless stalled
// rst_n is synchronous: it clears the sequencer and the result valid
// a result waits in the output register while the next item is taken and scanned
`timescale 1ns / 1ps
`default_nettype none

module dash_pattern_run_length_encoder_core
  import dprle_pkg::*;
#(
  parameter int PATTERN_BITS = 16
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire dprle_in_t  in_data,
  output logic            out_valid,
  input  wire logic       out_stall,
  output dprle_out_t      out_data
);

  localparam int PB = PATTERN_BITS;
  localparam int CW = $clog2(PB + 1);
  localparam int SW = (CW + 1 > RUN_W) ? CW + 1 : RUN_W;

  dprle_state_t            state_r, state_nxt;
  logic [PB-1:0]           pat_r, pat_nxt;
  logic [PB-1:0]           save_r, save_nxt;
  logic [PB-1:0]           pat_in;
  logic signed [TAG_W-1:0] tag_r, tag_nxt;
  logic [CW-1:0]           pos_r, pos_nxt;
  logic [CW-1:0]           offset_r, offset_nxt;
  logic [CW-1:0]           nruns_r, nruns_nxt;
  logic [CW-1:0]           len_r, len_nxt;
  logic                    seen_r, seen_nxt;
  logic                    prev_r, prev_nxt;
  logic [RUN_W-1:0]        k_r, k_nxt;
  dprle_out_t              out_r, out_nxt;
  logic                    out_valid_r, out_valid_nxt;

  logic                    out_free;
  logic                    msb, nxt_bit, last_bit, run_end;
  logic                    fold_c, append_c, more_c, fold_here;
  logic [SW-1:0]           list_len, off_ext, len_sum;
  logic [RUN_W-1:0]        count_c, k_inc;
  logic [CW-1:0]           len_inc;

  // pattern bits above the field width read as zero
  for (genvar gi = 0; gi < PB; gi++) begin : g_pat
    if (gi < PAT_W) begin : g_used
      assign pat_in[gi] = in_data.pattern[gi];
    end else begin : g_zero
      assign pat_in[gi] = 1'b0;
    end
  end

  assign out_free = !out_valid_r || !out_stall;
  assign msb      = pat_r[PB-1];
  assign nxt_bit  = pat_r[PB-2];
  assign last_bit = (pos_r == CW'(PB - 1));
  assign run_end  = last_bit || (nxt_bit != msb);

  // list shape from the scan pass
  assign fold_c    = (offset_r != '0) && (nruns_r != '0) && !nruns_r[0];
  assign append_c  = (offset_r != '0) && !fold_c;
  assign list_len  = SW'(nruns_r) + SW'(append_c);
  assign count_c   = (list_len > SW'(MAX_RESULTS)) ? RUN_W'(MAX_RESULTS)
                                                   : list_len[RUN_W-1:0];
  assign more_c    = (k_r < count_c);
  assign fold_here = fold_c && (SW'(k_r) == SW'(nruns_r) - SW'(1));
  assign off_ext   = SW'(offset_r);
  assign len_inc   = len_r + CW'(1);
  assign len_sum   = SW'(len_inc) + (fold_here ? off_ext : SW'(0));
  assign k_inc     = k_r + RUN_W'(1);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_SCAN;
      ST_SCAN: if (last_bit) state_nxt = ST_EMIT;
      ST_EMIT: if (out_free && last_bit) state_nxt = ST_TAIL;
      ST_TAIL: begin
        if (!(append_c && more_c) || out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = (state_r != ST_IDLE);
    out_valid = out_valid_r;
    out_data  = out_r;
  end

  always_comb begin
    pat_nxt       = pat_r;
    save_nxt      = save_r;
    tag_nxt       = tag_r;
    pos_nxt       = pos_r;
    offset_nxt    = offset_r;
    nruns_nxt     = nruns_r;
    len_nxt       = len_r;
    seen_nxt      = seen_r;
    prev_nxt      = prev_r;
    k_nxt         = k_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;

    out_nxt.slot_tag_out = out_r.slot_tag_out;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          pat_nxt    = pat_in;
          save_nxt   = pat_in;
          tag_nxt    = in_data.slot_tag;
          pos_nxt    = '0;
          offset_nxt = '0;
          nruns_nxt  = '0;
          seen_nxt   = 1'b0;
          prev_nxt   = 1'b0;
        end
      end
      ST_SCAN: begin
        pat_nxt = pat_r << 1;
        pos_nxt = pos_r + CW'(1);
        if (!seen_r) begin
          if (!msb) begin
            offset_nxt = offset_r + CW'(1);
          end else begin
            seen_nxt  = 1'b1;
            nruns_nxt = CW'(1);
            prev_nxt  = 1'b1;
          end
        end else if (msb != prev_r) begin
          nruns_nxt = nruns_r + CW'(1);
          prev_nxt  = msb;
        end
        if (last_bit) begin
          pat_nxt  = save_r;
          pos_nxt  = '0;
          seen_nxt = 1'b0;
          len_nxt  = '0;
          k_nxt    = '0;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          pat_nxt = pat_r << 1;
          pos_nxt = pos_r + CW'(1);
          // leading zeros are skipped, everything after belongs to a run
          if (seen_r || msb) begin
            seen_nxt = 1'b1;
            if (run_end) begin
              len_nxt = '0;
              if (more_c) begin
                out_nxt.slot_tag_out = tag_r;
                out_nxt.run_index    = k_r[IDX_W-1:0];
                out_nxt.run_length   = len_sum[RUN_W-1:0];
                out_nxt.start_offset = off_ext[RUN_W-1:0];
                out_nxt.run_count    = count_c;
                out_nxt.last_run     = (k_inc == count_c);
                out_valid_nxt        = 1'b1;
                k_nxt                = k_inc;
              end
            end else begin
              len_nxt = len_inc;
            end
          end
        end
      end
      ST_TAIL: begin
        if (append_c && more_c && out_free) begin
          out_nxt.slot_tag_out = tag_r;
          out_nxt.run_index    = k_r[IDX_W-1:0];
          out_nxt.run_length   = off_ext[RUN_W-1:0];
          out_nxt.start_offset = off_ext[RUN_W-1:0];
          out_nxt.run_count    = count_c;
          out_nxt.last_run     = (k_inc == count_c);
          out_valid_nxt        = 1'b1;
          k_nxt                = k_inc;
        end
      end
      default: begin
        pat_nxt = pat_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pat_r    <= pat_nxt;
    save_r   <= save_nxt;
    tag_r    <= tag_nxt;
    pos_r    <= pos_nxt;
    offset_r <= offset_nxt;
    nruns_r  <= nruns_nxt;
    len_r    <= len_nxt;
    seen_r   <= seen_nxt;
    prev_r   <= prev_nxt;
    k_r      <= k_nxt;
    out_r    <= out_nxt;
  end

endmodule

`default_nettype wire

### verif/tb_dash_pattern_run_length_encoder_core.sv
// tb_dash_pattern_run_length_encoder_core: self-checking bench for the dash pattern encoder
// clocked driver and monitor with an in-bench dash list predictor and random idling
// depends on dprle_pkg and dash_pattern_run_length_encoder_core
`timescale 1ns / 1ps

module tb_dash_pattern_run_length_encoder_core;
  import dprle_pkg::*;

  localparam int N_PHASES    = 4;
  localparam int RAND_ITEMS  = 115;
  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 80;

  typedef struct {
    dprle_in_t item;
    int        phase;
    bit        drain;
  } pending_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  dprle_in_t  in_data;
  logic       out_valid;
  logic       out_stall;
  dprle_out_t out_data;

  pending_t   pattern_q[$];
  dprle_out_t dash_elems_q[$];

  int  send_idle_pct[N_PHASES] = '{0, 49, 0, 22};
  int  recv_stall_pct[N_PHASES] = '{0, 0, 49, 22};
  int  cur_phase;
  bit  in_fire;
  int  quiet_cycles;
  int  mismatches;
  int  patterns_sent;
  int  elems_checked;

  dash_pattern_run_length_encoder_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // expected dash list for one pattern, in list order
  task automatic predict_dash_list(input dprle_in_t item);
    int unsigned lens[PAT_W+1];
    int          n;
    int          pos;
    int          offset;
    int          start;
    bit          want;
    dprle_out_t  r;
    n = 0;
    pos = 0;
    want = 1'b1;
    while (pos < PAT_W && item.pattern[PAT_W-1-pos] == 1'b0) pos++;
    offset = pos;
    while (pos < PAT_W) begin
      start = pos;
      while (pos < PAT_W && item.pattern[PAT_W-1-pos] == want) pos++;
      lens[n] = pos - start;
      n++;
      want = ~want;
    end
    if (offset != 0) begin
      if (n > 0 && (n % 2) == 0) begin
        lens[n-1] += offset;
      end else begin
        lens[n] = offset;
        n++;
      end
    end
    if (n > MAX_RESULTS) n = MAX_RESULTS;
    for (int k = 0; k < n; k++) begin
      r.slot_tag_out = item.slot_tag;
      r.run_index    = IDX_W'(k);
      r.run_length   = RUN_W'(lens[k]);
      r.start_offset = RUN_W'(offset);
      r.run_count    = RUN_W'(n);
      r.last_run     = (k == n - 1);
      dash_elems_q.push_back(r);
    end
  endtask

  // driver: new transfer only once the previous one has gone
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_fire) begin
        if (pattern_q.size() == 0) begin
          in_valid <= 1'b0;
        end else if (pattern_q[0].drain && dash_elems_q.size() != 0) begin
          in_valid <= 1'b0;
        end else if ($urandom_range(0, 99) < send_idle_pct[pattern_q[0].phase]) begin
          in_valid <= 1'b0;
          cur_phase <= pattern_q[0].phase;
        end else begin
          in_valid  <= 1'b1;
          in_data   <= pattern_q[0].item;
          cur_phase <= pattern_q[0].phase;
          void'(pattern_q.pop_front());
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct[cur_phase]);
    end
  end

  // monitor: prediction on input transfer, checking on result transfer
  always @(posedge clk) begin
    dprle_out_t exp_r;
    in_fire <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      predict_dash_list(in_data);
      patterns_sent <= patterns_sent + 1;
    end
    if (rst_n && out_valid && !out_stall) begin
      elems_checked <= elems_checked + 1;
      if (dash_elems_q.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10)
          $display("unexpected result: tag %0d idx %0d len %0d off %0d cnt %0d last %0b",
                   out_data.slot_tag_out, out_data.run_index, out_data.run_length,
                   out_data.start_offset, out_data.run_count, out_data.last_run);
      end else begin
        exp_r = dash_elems_q.pop_front();
        if (out_data.slot_tag_out !== exp_r.slot_tag_out ||
            out_data.run_index    !== exp_r.run_index    ||
            out_data.run_length   !== exp_r.run_length   ||
            out_data.start_offset !== exp_r.start_offset ||
            out_data.run_count    !== exp_r.run_count    ||
            out_data.last_run     !== exp_r.last_run) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("mismatch: exp tag %0d idx %0d len %0d off %0d cnt %0d last %0b / got tag %0d idx %0d len %0d off %0d cnt %0d last %0b",
                     exp_r.slot_tag_out, exp_r.run_index, exp_r.run_length,
                     exp_r.start_offset, exp_r.run_count, exp_r.last_run,
                     out_data.slot_tag_out, out_data.run_index, out_data.run_length,
                     out_data.start_offset, out_data.run_count, out_data.last_run);
        end
      end
    end
    if (rst_n && !(in_valid && !in_stall) && !(out_valid && !out_stall))
      quiet_cycles <= quiet_cycles + 1;
    else
      quiet_cycles <= 0;
  end

  initial begin : watchdog
    while (quiet_cycles < STALL_LIMIT) @(posedge clk);
    $display("tb_dash_pattern_run_length_encoder_core failed");
    $finish;
  end

  initial begin : stimulus
    logic [PAT_W-1:0] directed_pats[22];
    logic [TAG_W-1:0] directed_tags[4];
    pending_t         e;
    logic [PAT_W-1:0] p;
    int               pos;
    int               len;
    int               shape;
    bit               lvl;
    directed_pats = '{16'h0000, 16'hFFFF, 16'h8000, 16'h0001, 16'hAAAA, 16'h5555,
                      16'h00FF, 16'hFF00, 16'h0F0F, 16'hF0F0, 16'h7FFE, 16'h8001,
                      16'h1000, 16'h0FFF, 16'h00F0, 16'h4000, 16'h7FFF, 16'hFFFE,
                      16'h0002, 16'hC003, 16'h3FFC, 16'h6666};
    directed_tags = '{8'h80, 8'h7F, 8'h00, 8'hFF};
    in_valid      = 1'b0;
    in_data       = '0;
    out_stall     = 1'b0;
    rst_n         = 1'b0;
    cur_phase     = 0;
    in_fire       = 1'b0;
    quiet_cycles  = 0;
    mismatches    = 0;
    patterns_sent = 0;
    elems_checked = 0;

    for (int i = 0; i < 22; i++) begin
      e.item.slot_tag = directed_tags[i % 4];
      e.item.pattern  = directed_pats[i];
      e.phase         = 0;
      e.drain         = (i == 11);
      pattern_q.push_back(e);
    end
    for (int ph = 0; ph < N_PHASES; ph++) begin
      for (int i = 0; i < RAND_ITEMS; i++) begin
        shape = $urandom_range(0, 99);
        if (shape < 40) begin
          // runs of one to four bits after a leading gap of up to six bits, or none
          p   = '0;
          pos = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          lvl = 1'b1;
          while (pos < PAT_W) begin
            len = $urandom_range(1, 4);
            for (int j = 0; j < len && pos < PAT_W; j++) begin
              p[PAT_W-1-pos] = lvl;
              pos++;
            end
            lvl = ~lvl;
          end
        end else if (shape < 70) begin
          p = PAT_W'($urandom);
        end else if (shape < 85) begin
          p = PAT_W'($urandom) & PAT_W'($urandom) & PAT_W'($urandom);
          if ($urandom_range(0, 1)) p = ~p;
        end else begin
          p = PAT_W'($urandom) >> $urandom_range(1, PAT_W);
        end
        e.item.slot_tag = TAG_W'($urandom);
        e.item.pattern  = p;
        e.phase         = ph;
        e.drain         = (i == 0) || ($urandom_range(0, 39) == 0);
        pattern_q.push_back(e);
      end
    end

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    while (pattern_q.size() != 0 || in_valid || dash_elems_q.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("%0d patterns sent over %0d idling phases, %0d dash elements checked",
             patterns_sent, N_PHASES, elems_checked);
    $display("%0d mismatches, %0d elements still expected", mismatches, dash_elems_q.size());
    if (mismatches == 0 && dash_elems_q.size() == 0) begin
      $display("tb_dash_pattern_run_length_encoder_core passed");
    end else begin
      $display("tb_dash_pattern_run_length_encoder_core failed");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/dprle_pkg.sv
hw/rtl/dash_pattern_run_length_encoder_core.sv
verif/tb_dash_pattern_run_length_encoder_core.sv
